/* hdl/mm4_pkg.sv */
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types, widths and microprogram for the 4x4 fixed-point matrix product.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;   // shifted product fits here
    localparam int ACC_W     = TERM_W + 2;           // four terms summed
    localparam int STEP_W    = 3;

    typedef logic [STEP_W-1:0] step_t;

    // program addresses
    localparam step_t STEP_CLR  = 3'd0;
    localparam step_t STEP_RD   = 3'd1;
    localparam step_t STEP_MUL  = 3'd2;
    localparam step_t STEP_ACC  = 3'd3;
    localparam step_t STEP_EMIT = 3'd4;
    localparam step_t STEP_IDLE = 3'd5;

    typedef enum logic [1:0] {
        COND_NEXT,     // fall through
        COND_GO,       // jump on accepted word with go, else hold
        COND_K_LOOP,   // jump while more terms remain
        COND_EMIT      // hold until output free; jump unless last product
    } cond_t;

    typedef struct packed {
        logic  load;   // input port open
        logic  clr;    // clear accumulator and term count
        logic  rd;     // read both stores
        logic  mul;    // register the product
        logic  acc;    // accumulate shifted product, advance term
        logic  emit;   // load output register
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic go_taken;
        logic k_last;
        logic p_last;
        logic out_free;
    } seq_status_t;

    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        w = '{load: 1'b0, clr: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
              cond: COND_NEXT, target: STEP_IDLE};
        unique case (step)
            STEP_CLR:  w.clr  = 1'b1;
            STEP_RD:   w.rd   = 1'b1;
            STEP_MUL:  w.mul  = 1'b1;
            STEP_ACC:
            begin
                w.acc    = 1'b1;
                w.cond   = COND_K_LOOP;
                w.target = STEP_RD;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_EMIT;
                w.target = STEP_CLR;
            end
            STEP_IDLE:
            begin
                w.load   = 1'b1;
                w.cond   = COND_GO;
                w.target = STEP_CLR;
            end
            default:
            begin
                w.cond   = COND_NEXT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/matrix4x4_multiply.sv */
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// 4x4 signed fixed-point matrix product with element-wise loading.
// ----------------------------------------------------------------------------
// Each input word writes one element (element_index 0..15) of the left
// (matrix_select 0) or right (matrix_select 1) store. A word with go set
// is stored first; then the block emits 16 product words in index order
// p = i + 4*j, where product p = sum over k of left[4i+k] * right[j+4k].
// Every 64-bit partial product is shifted right arithmetically by FRAC_BITS
// (floor), the four terms are summed exactly and the sum saturates to 32
// bits. last_result marks the sixteenth word. No new input word is taken
// until the whole product has been handed to the output register. Each
// product word is built by a clear, then four rounds of store read,
// multiply and accumulate on the single 32x32 multiplier, then the output
// load, which waits for a free output register. Both stores must be fully
// written before the first go; unwritten entries give undefined results.
// ----------------------------------------------------------------------------
module matrix4x4_multiply
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     matrix_select,
    input  logic [3:0]               element_index,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     go,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [3:0]               result_index,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last_result
);

    ctrl_word_t  ctrl;
    seq_status_t status;

    // element stores
    logic [DATA_W-1:0] left_mem  [16];
    logic [DATA_W-1:0] right_mem [16];

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [1:0]               k_reg;
    logic [3:0]               p_reg;

    logic                     out_valid_reg;
    logic [3:0]               out_index_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;

    logic                     in_fire;
    logic                     out_free;
    logic                     emit_fire;
    logic [3:0]               left_addr;
    logic [3:0]               right_addr;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [TERM_W-1:0] term;
    logic signed [DATA_W-1:0] sat_value;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    assign in_ready  = ctrl.load;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = ctrl.emit && out_free;

    assign status.go_taken = in_fire && go;
    assign status.k_last   = (k_reg == 2'd3);
    assign status.p_last   = (p_reg == 4'd15);
    assign status.out_free = out_free;

    mm4_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // p = i + 4j: left row i, right column j
    assign left_addr  = {p_reg[1:0], k_reg};
    assign right_addr = {k_reg, p_reg[3:2]};

    always_ff @(posedge clk)
    begin
        if (in_fire && !matrix_select)
        begin
            left_mem[element_index] <= element_value;
        end
        if (ctrl.rd)
        begin
            a_reg <= left_mem[left_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && matrix_select)
        begin
            right_mem[element_index] <= element_value;
        end
        if (ctrl.rd)
        begin
            b_reg <= right_mem[right_addr];
        end
    end

    // floor shift; result always fits TERM_W
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign term       = prod_shift[TERM_W-1:0];

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (acc_reg < SAT_MIN)
        begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = acc_reg[DATA_W-1:0];
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
        end
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
        if (emit_fire)
        begin
            out_index_reg <= p_reg;
            out_value_reg <= sat_value;
            out_last_reg  <= (p_reg == 4'd15);
        end
    end

    // loop counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr)
            begin
                k_reg <= '0;
            end
            else if (ctrl.acc)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (emit_fire)
            begin
                p_reg <= p_reg + 4'd1;   // wraps to 0 after the last word
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_index_reg;
    assign result_value = out_value_reg;
    assign last_result  = out_last_reg;

endmodule

/* hdl/mm4_seq.sv */
// ----------------------------------------------------------------------------
// mm4_seq
// Step counter and control store; sequences one product element at a time.
// ----------------------------------------------------------------------------
module mm4_seq
    import mm4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output ctrl_word_t  ctrl
);

    step_t step_reg;
    step_t step_next;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.cond)
            COND_NEXT:   step_next = step_reg + 3'd1;
            COND_GO:     step_next = status.go_taken ? ctrl.target : step_reg;
            COND_K_LOOP: step_next = status.k_last ? step_reg + 3'd1 : ctrl.target;
            COND_EMIT:
            begin
                if (status.out_free)
                begin
                    step_next = status.p_last ? step_reg + 3'd1 : ctrl.target;
                end
            end
            default:     step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* tb/matrix4x4_multiply_checker.sv */
// ----------------------------------------------------------------------------
// matrix4x4_multiply_checker
// Watches both channels of the 4x4 fixed-point matrix product and checks
// every result word against a local prediction.
// ----------------------------------------------------------------------------
// Each accepted input word updates a local copy of the left or right store.
// A word with go queues the sixteen expected product words. Each accepted
// output word is checked against the oldest queued product word.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_checker
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     matrix_select,
    input  logic [3:0]               element_index,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     go,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [3:0]               result_index,
    input  logic signed [DATA_W-1:0] result_value,
    input  logic                     last_result,
    output int                       mismatch_count,
    output int                       products_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM   = 4;
    localparam int CELLS = DIM * DIM;

    localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (DATA_W - 1));

    typedef struct packed {
        logic [3:0]               p_index;
        logic signed [DATA_W-1:0] p_value;
        logic                     p_last;
    } product_word_t;

    logic signed [DATA_W-1:0] left_store  [CELLS];
    logic signed [DATA_W-1:0] right_store [CELLS];
    product_word_t            pending_products [$];

    initial
    begin
        mismatch_count = 0;
        products_owed  = 0;
    end

    // row i of left times column j of right; each term floored by FRAC_BITS,
    // summed exactly, then clamped to the word range
    function automatic logic signed [DATA_W-1:0] product_cell(input int row, input int col);
        longint term;
        longint sum;
        sum = 0;
        for (int k = 0; k < DIM; k++)
        begin
            term = longint'(left_store[DIM * row + k]) * longint'(right_store[col + DIM * k]);
            sum += term >>> FRAC_BITS;
        end
        if (sum > WORD_MAX)
            sum = WORD_MAX;
        if (sum < WORD_MIN)
            sum = WORD_MIN;
        return DATA_W'(sum);
    endfunction

    function automatic void queue_products();
        product_word_t w;
        for (int p = 0; p < CELLS; p++)
        begin
            w.p_index = 4'(p);
            w.p_value = product_cell(p % DIM, p / DIM);
            w.p_last  = (p == CELLS - 1);
            pending_products.push_back(w);
        end
    endfunction

    function automatic void check_result();
        product_word_t w;
        if (pending_products.size() == 0)
        begin
            $display("%0t: unexpected result word index %0d value %0d last %0b",
                     $time, result_index, result_value, last_result);
            mismatch_count++;
            return;
        end
        w = pending_products.pop_front();
        if (result_index !== w.p_index)
        begin
            $display("%0t: result_index expected %0d, got %0d", $time, w.p_index, result_index);
            mismatch_count++;
        end
        if (result_value !== w.p_value)
        begin
            $display("%0t: result_value at index %0d expected %0d, got %0d",
                     $time, w.p_index, w.p_value, result_value);
            mismatch_count++;
        end
        if (last_result !== w.p_last)
        begin
            $display("%0t: last_result at index %0d expected %0b, got %0b",
                     $time, w.p_index, w.p_last, last_result);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (matrix_select)
                    right_store[element_index] = element_value;
                else
                    left_store[element_index] = element_value;
                if (go)
                    queue_products();
            end
            if (out_valid && out_ready)
                check_result();
            products_owed <= pending_products.size();
        end
    end

endmodule

/* tb/matrix4x4_multiply_tb.sv */
// ----------------------------------------------------------------------------
// matrix4x4_multiply_tb
// Self-checking bench for the 4x4 fixed-point matrix product.
// ----------------------------------------------------------------------------
// Loads both stores completely with corner values, then runs random rounds:
// partial updates of random elements ending in go, full rewrites of one
// matrix, and go-less noise. The sender works in bursts with random gaps and
// sometimes holds off until all products are out; the receiver switches
// between several stall patterns. The checker predicts and compares.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_tb
    import mm4_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TOTAL_WORDS   = 450;        // directed words included
    localparam int  CYCLE_LIMIT   = 1_000_000;
    localparam int  SETTLE_CYCLES = 64;
    localparam logic SEL_LEFT     = 1'b0;
    localparam logic SEL_RIGHT    = 1'b1;

    localparam logic signed [DATA_W-1:0] WORD_HI = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_LO = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF  = 32'sh0000_8000;

    typedef enum int {VAL_SMALL, VAL_FULL, VAL_CORNER} value_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} rx_mode_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic                     matrix_select = 1'b0;
    logic [3:0]               element_index = '0;
    logic signed [DATA_W-1:0] element_value = '0;
    logic                     go            = 1'b0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic [3:0]               result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     last_result;

    int mismatch_count;
    int products_owed;
    int cycle_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;

    // receiver stall pattern state
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;

    matrix4x4_multiply u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .matrix_select (matrix_select),
        .element_index (element_index),
        .element_value (element_value),
        .go            (go),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_index  (result_index),
        .result_value  (result_value),
        .last_result   (last_result)
    );

    matrix4x4_multiply_checker u_product_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .matrix_select  (matrix_select),
        .element_index  (element_index),
        .element_value  (element_value),
        .go             (go),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_index   (result_index),
        .result_value   (result_value),
        .last_result    (last_result),
        .mismatch_count (mismatch_count),
        .products_owed  (products_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: the slowest legal run (every word with go, every result
    // stalled for long) stays well below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d product words still owed",
                     cycle_count, products_owed);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: picks a stall pattern for a random stretch of cycles. Open
    // stretches never stall a result, choked ones give long stalls.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   out_ready = 1'b1;
            RX_COIN:   out_ready = 1'($urandom_range(0, 1));
            RX_MOSTLY: out_ready = ($urandom_range(0, 7) != 0);
            default:   out_ready = ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic value_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return VAL_SMALL;
        else if (r < 17)
            return VAL_FULL;
        return VAL_CORNER;
    endfunction

    // small values keep sums in range so the arithmetic, not the clamp, is
    // what most products exercise
    function automatic logic signed [DATA_W-1:0] random_element(input value_kind_t kind);
        logic signed [DATA_W-1:0] corner_vals [6];
        corner_vals = '{WORD_HI, WORD_LO, '0, -1, 1, Q_ONE};
        case (kind)
            VAL_SMALL:  return DATA_W'(int'($urandom_range(0, 32'h10_0000)) - 32'sh8_0000);
            VAL_FULL:   return $urandom();
            default:    return corner_vals[$urandom_range(0, 5)];
        endcase
    endfunction

    // Present one word at the falling edge, hold it until taken, then either
    // keep valid up for the next word of the burst or drop it for a gap.
    task automatic send_word(input logic sel, input logic [3:0] idx,
                             input logic signed [DATA_W-1:0] val, input logic go_flag);
        in_valid      = 1'b1;
        matrix_select = sel;
        element_index = idx;
        element_value = val;
        go            = go_flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // sender holds off until every queued product word has been taken
    task automatic wait_products_drained();
        in_valid = 1'b0;
        while (products_owed != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] row_fill [4];
        logic signed [DATA_W-1:0] col_fill [4];
        value_kind_t              kind;
        logic                     sel;
        int                       shape;
        int                       len;

        row_fill = '{WORD_HI, WORD_LO, 1, Q_ONE};
        col_fill = '{WORD_HI, WORD_LO, '0, -1};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Full load of both stores before the first go. Left rows are
        // max, min, one LSB and 1.0; right columns are max, min, zero and -1
        // LSB. That gives positive and negative saturation (max*max,
        // min*min, min*max), zero products, and floor rounding of tiny
        // negative terms (one LSB times -1 LSB, max times -1 LSB).
        for (int n = 0; n < 16; n++)
            send_word(SEL_LEFT, 4'(n), row_fill[n / 4], 1'b0);
        for (int n = 0; n < 16; n++)
            send_word(SEL_RIGHT, 4'(n), col_fill[n % 4], n == 15);
        wait_products_drained();

        // go on a left-store word; fractional operands
        send_word(SEL_LEFT, 4'd5, -1, 1'b1);
        send_word(SEL_RIGHT, 4'd0, -Q_HALF, 1'b0);
        send_word(SEL_LEFT, 4'd0, Q_ONE + Q_HALF, 1'b1);
        send_word(SEL_RIGHT, 4'd15, WORD_LO, 1'b0);
        send_word(SEL_LEFT, 4'd15, WORD_LO, 1'b1);

        // Random rounds: mostly runs of random element updates closed by go,
        // some full rewrites of one matrix with one value class, and runs
        // with no go at all.
        while (words_sent < TOTAL_WORDS)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 2)
            begin
                kind = pick_kind();
                sel  = 1'($urandom_range(0, 1));
                for (int n = 0; n < 16; n++)
                    send_word(sel, 4'(n), random_element(kind), n == 15);
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int n = 0; n < len; n++)
                    send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              random_element(pick_kind()),
                              (n == len - 1) && ($urandom_range(0, 5) != 0));
            end
            if ($urandom_range(0, 7) == 0)
                wait_products_drained();
        end

        // drain, then leave room for any stray word to show up
        wait_products_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mm4_pkg.sv
hdl/mm4_seq.sv
hdl/matrix4x4_multiply.sv
tb/matrix4x4_multiply_checker.sv
tb/matrix4x4_multiply_tb.sv
